### rtl/core/vt4_pkg.sv
`default_nettype none
package vt4_pkg;

   localparam int DIM       = 4;
   localparam int NUM_REGS  = (DIM * DIM) / 2;
   localparam int COMP_W    = 32;
   localparam int REG_W     = 2 * COMP_W;
   localparam int FRAC_BITS = 16;
   localparam int CSR_IDX_W = 4;
   localparam int PROD_W    = 2 * COMP_W;
   localparam int PAIR_W    = PROD_W + 1;
   localparam int SUM_W     = PROD_W + 2;
   localparam int SHIFT_W   = SUM_W - FRAC_BITS;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_ROW0_COLS01 = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_ROW0_COLS23 = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_ROW1_COLS01 = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_ROW1_COLS23 = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_ROW2_COLS01 = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_ROW2_COLS23 = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] CSR_ROW3_COLS01 = CSR_IDX_W'(6);
   localparam logic [CSR_IDX_W-1:0] CSR_ROW3_COLS23 = CSR_IDX_W'(7);

   localparam logic [COMP_W-1:0] Q_ONE = COMP_W'(1 << FRAC_BITS);
   localparam logic [COMP_W-1:0] Q_MAX = {1'b0, {(COMP_W-1){1'b1}}};
   localparam logic [COMP_W-1:0] Q_MIN = {1'b1, {(COMP_W-1){1'b0}}};

   typedef logic [COMP_W-1:0]                 comp_type;
   typedef comp_type [DIM-1:0]                vec_type;
   typedef vec_type  [DIM-1:0]                mat_type;
   typedef logic [REG_W-1:0]                  csr_type;
   typedef csr_type  [NUM_REGS-1:0]           csr_file_type;
   typedef logic [PROD_W-1:0]                 prod_type;
   typedef prod_type [DIM-1:0][DIM-1:0]       prod_mat_type;
   typedef logic [PAIR_W-1:0]                 pair_type;
   typedef pair_type [DIM-1:0][DIM/2-1:0]     pair_mat_type;
   typedef logic [SUM_W-1:0]                  sum_type;
   typedef sum_type  [DIM-1:0]                sum_vec_type;

   // Identity matrix after reset.
   localparam csr_file_type CSR_RESET = '{
      {Q_ONE, {COMP_W{1'b0}}},      // row3_cols23: column 3 is one
      {REG_W{1'b0}},                // row3_cols01
      {{COMP_W{1'b0}}, Q_ONE},      // row2_cols23: column 2 is one
      {REG_W{1'b0}},                // row2_cols01
      {REG_W{1'b0}},                // row1_cols23
      {Q_ONE, {COMP_W{1'b0}}},      // row1_cols01: column 1 is one
      {REG_W{1'b0}},                // row0_cols23
      {{COMP_W{1'b0}}, Q_ONE}       // row0_cols01: column 0 is one
   };

endpackage
`default_nettype wire

### rtl/core/vt4_mul_stage.sv
`default_nettype none
module vt4_mul_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire vt4_pkg::vec_type      vertex,
   input  wire vt4_pkg::mat_type      matrix,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output vt4_pkg::prod_mat_type      prod
);
   import vt4_pkg::*;

   logic         valid_ff, valid_in;
   prod_mat_type prod_ff, prod_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      for (int r = 0; r < DIM; r++) begin
         for (int c = 0; c < DIM; c++) begin
            prod_in[r][c] = PROD_W'($signed(matrix[r][c]) * $signed(vertex[c]));
         end
      end
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         prod_ff <= prod_in;
      end
   end

   assign out_valid = valid_ff;
   assign prod      = prod_ff;

endmodule
`default_nettype wire

### rtl/core/vt4_sum_stage.sv
`default_nettype none
module vt4_sum_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire vt4_pkg::prod_mat_type prod,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output vt4_pkg::sum_vec_type       sum
);
   import vt4_pkg::*;

   logic         pair_valid_ff, pair_valid_in;
   logic         sum_valid_ff, sum_valid_in;
   logic         pair_ready, sum_ready;
   pair_mat_type pair_ff, pair_in;
   sum_vec_type  sum_ff, sum_in;

   assign sum_ready  = !sum_valid_ff || out_ready;
   assign pair_ready = !pair_valid_ff || sum_ready;
   assign in_ready   = pair_ready;

   // First level adds column pairs, second level closes each row; both
   // keep every bit so the row sum is exact.
   always_comb begin
      for (int r = 0; r < DIM; r++) begin
         for (int h = 0; h < DIM / 2; h++) begin
            pair_in[r][h] = PAIR_W'($signed(prod[r][2*h]))
                          + PAIR_W'($signed(prod[r][2*h+1]));
         end
         sum_in[r] = SUM_W'($signed(pair_ff[r][0])) + SUM_W'($signed(pair_ff[r][1]));
      end
      pair_valid_in = pair_ready ? in_valid : pair_valid_ff;
      sum_valid_in  = sum_ready ? pair_valid_ff : sum_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
      end else begin
         pair_valid_ff <= pair_valid_in;
         sum_valid_ff  <= sum_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && pair_ready) begin
         pair_ff <= pair_in;
      end
      if (pair_valid_ff && sum_ready) begin
         sum_ff <= sum_in;
      end
   end

   assign out_valid = sum_valid_ff;
   assign sum       = sum_ff;

endmodule
`default_nettype wire

### rtl/core/vt4_sat_stage.sv
`default_nettype none
module vt4_sat_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire vt4_pkg::sum_vec_type  sum,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output vt4_pkg::vec_type           result,
   output logic                       saturated
);
   import vt4_pkg::*;

   logic                valid_ff, valid_in;
   vec_type             result_ff, result_in;
   logic                sat_ff, sat_in;
   logic [SHIFT_W-1:0]  shifted;
   logic [SHIFT_W-COMP_W:0] upper;
   logic [DIM-1:0]      clip;

   assign in_ready = !valid_ff || out_ready;

   // Dropping the low fraction bits of a two's complement sum is a floor
   // division; the value fits when every bit from bit 31 up is equal.
   always_comb begin
      shifted = '0;
      upper   = '0;
      for (int r = 0; r < DIM; r++) begin
         shifted = sum[r][SUM_W-1:FRAC_BITS];
         upper   = shifted[SHIFT_W-1:COMP_W-1];
         clip[r] = !((&upper) || !(|upper));
         if (!clip[r]) begin
            result_in[r] = shifted[COMP_W-1:0];
         end else if (shifted[SHIFT_W-1]) begin
            result_in[r] = Q_MIN;
         end else begin
            result_in[r] = Q_MAX;
         end
      end
      sat_in   = |clip;
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         result_ff <= result_in;
         sat_ff    <= sat_in;
      end
   end

   assign out_valid = valid_ff;
   assign result    = result_ff;
   assign saturated = sat_ff;

endmodule
`default_nettype wire

### rtl/core/vertex_transform_4x4_top.sv
`default_nettype none
// Transforms one homogeneous vertex (x, y, z, w) per clock by a 4x4 matrix of
// signed Q16.16 entries held in eight 64-bit registers, two entries each
// (the even column in the low half); reset loads the identity matrix. Each
// output component is the exact sum of four products shifted right by 16
// (rounding toward minus infinity) and saturated to 32 bits, with one flag
// set when any component clipped. The datapath is a four-stage pipeline:
// sixteen 32x32 multipliers, a pair adder level, a row adder level and a
// saturation stage, and one vertex can enter every cycle while the result
// side does not stall. A stall on the result side backs up
// stage by stage, and bubbles in the pipeline still let new vertices in.
// The matrix is read live by the multipliers; write it only while the
// pipeline is empty. Writes to an index above 7 are ignored.
module vertex_transform_4x4_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [vt4_pkg::COMP_W-1:0]     req_in_x,
   input  wire logic [vt4_pkg::COMP_W-1:0]     req_in_y,
   input  wire logic [vt4_pkg::COMP_W-1:0]     req_in_z,
   input  wire logic [vt4_pkg::COMP_W-1:0]     req_in_w,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [vt4_pkg::COMP_W-1:0]          rsp_out_x,
   output logic [vt4_pkg::COMP_W-1:0]          rsp_out_y,
   output logic [vt4_pkg::COMP_W-1:0]          rsp_out_z,
   output logic [vt4_pkg::COMP_W-1:0]          rsp_out_w,
   output logic                                rsp_saturated,
   input  wire logic                           csr_wen,
   input  wire logic [vt4_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [vt4_pkg::REG_W-1:0]      csr_wdata
);
   import vt4_pkg::*;

   csr_file_type csr_ff, csr_in;
   mat_type      matrix;
   vec_type      vertex;
   vec_type      result;
   prod_mat_type prod;
   sum_vec_type  sum;
   logic         mul_ready, mul_valid;
   logic         sum_ready, sum_valid;
   logic         sat_ready;

   always_comb begin
      csr_in = csr_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_ROW0_COLS01: csr_in[0] = csr_wdata;
            CSR_ROW0_COLS23: csr_in[1] = csr_wdata;
            CSR_ROW1_COLS01: csr_in[2] = csr_wdata;
            CSR_ROW1_COLS23: csr_in[3] = csr_wdata;
            CSR_ROW2_COLS01: csr_in[4] = csr_wdata;
            CSR_ROW2_COLS23: csr_in[5] = csr_wdata;
            CSR_ROW3_COLS01: csr_in[6] = csr_wdata;
            CSR_ROW3_COLS23: csr_in[7] = csr_wdata;
            default: csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= CSR_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   always_comb begin
      for (int r = 0; r < DIM; r++) begin
         for (int c = 0; c < DIM; c++) begin
            matrix[r][c] = csr_ff[r*(DIM/2) + c/2][(c%2)*COMP_W +: COMP_W];
         end
      end
   end

   assign vertex = {req_in_w, req_in_z, req_in_y, req_in_x};

   vt4_mul_stage u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (mul_ready),
      .vertex    (vertex),
      .matrix    (matrix),
      .out_valid (mul_valid),
      .out_ready (sum_ready),
      .prod      (prod)
   );

   vt4_sum_stage u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mul_valid),
      .in_ready  (sum_ready),
      .prod      (prod),
      .out_valid (sum_valid),
      .out_ready (sat_ready),
      .sum       (sum)
   );

   vt4_sat_stage u_sat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid),
      .in_ready  (sat_ready),
      .sum       (sum),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .result    (result),
      .saturated (rsp_saturated)
   );

   assign req_stall = !mul_ready;
   assign rsp_out_x = result[0];
   assign rsp_out_y = result[1];
   assign rsp_out_z = result[2];
   assign rsp_out_w = result[3];

endmodule
`default_nettype wire

### tb/sv/vertex_transform_4x4_top_tb.sv
`timescale 1ns / 100ps

module vertex_transform_4x4_top_tb;
   import vt4_pkg::*;

   typedef enum int {STYLE_FULL, STYLE_SMALL, STYLE_EXTREME, STYLE_MIXED} value_style_type;

   typedef struct packed {
      vec_type comp;
      logic    saturated;
   } vertex_result_type;

   localparam logic signed [SUM_W-1:0] SUM_CEIL  = 66'sd2147483647;
   localparam logic signed [SUM_W-1:0] SUM_FLOOR = -66'sd2147483648;

   localparam logic [CSR_IDX_W-1:0] MATRIX_REGS [NUM_REGS] = '{
      CSR_ROW0_COLS01, CSR_ROW0_COLS23, CSR_ROW1_COLS01, CSR_ROW1_COLS23,
      CSR_ROW2_COLS01, CSR_ROW2_COLS23, CSR_ROW3_COLS01, CSR_ROW3_COLS23
   };

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [COMP_W-1:0]    req_in_x, req_in_y, req_in_z, req_in_w;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [COMP_W-1:0]    rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_w;
   logic                 rsp_saturated;
   logic                 csr_wen;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [REG_W-1:0]     csr_wdata;

   // Copy of the matrix registers as the block should hold them.
   csr_file_type         matrix_shadow;
   vec_type              pending_vertices [$];
   vertex_result_type    predicted_results [$];
   string                comp_names [DIM] = '{"out_x", "out_y", "out_z", "out_w"};

   bit                   req_fired = 1'b0;
   int                   idle_pct = 0;
   int                   send_gap = 0;
   int                   stall_left = 0;
   int                   mismatch_count = 0;
   int                   vertices_sent = 0;
   int                   results_checked = 0;
   int                   saturated_seen = 0;
   int                   matrix_settings = 1;

   vertex_transform_4x4_top uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_x      (req_in_x),
      .req_in_y      (req_in_y),
      .req_in_z      (req_in_z),
      .req_in_w      (req_in_w),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_out_z     (rsp_out_z),
      .rsp_out_w     (rsp_out_w),
      .rsp_saturated (rsp_saturated),
      .csr_wen       (csr_wen),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Each row is dotted with the vertex in full width, then scaled back to
   // Q16.16 with a floor shift and clipped to 32 bits.
   function automatic vertex_result_type transform_vertex(input vec_type vtx);
      vertex_result_type      res;
      logic signed [SUM_W-1:0] acc, ea, eb, scaled;
      comp_type               e;
      res.saturated = 1'b0;
      for (int row = 0; row < DIM; row++) begin
         acc = '0;
         for (int col = 0; col < DIM; col++) begin
            e   = matrix_shadow[row * (DIM / 2) + col / 2][(col % 2) * COMP_W +: COMP_W];
            ea  = $signed(e);
            eb  = $signed(vtx[col]);
            acc = acc + ea * eb;
         end
         scaled = acc >>> FRAC_BITS;
         if (scaled > SUM_CEIL) begin
            res.comp[row] = Q_MAX;
            res.saturated = 1'b1;
         end else if (scaled < SUM_FLOOR) begin
            res.comp[row] = Q_MIN;
            res.saturated = 1'b1;
         end else begin
            res.comp[row] = scaled[COMP_W-1:0];
         end
      end
      return res;
   endfunction

   function automatic comp_type rand_q(input value_style_type style);
      comp_type        picks [7];
      value_style_type s;
      picks = '{Q_MAX, Q_MIN, '0, Q_ONE, -Q_ONE, '1, comp_type'(1)};
      s = style;
      if (s == STYLE_MIXED) begin
         case ($urandom_range(0, 99)) inside
            [0:39]:  s = STYLE_SMALL;
            [40:74]: s = STYLE_FULL;
            default: s = STYLE_EXTREME;
         endcase
      end
      case (s)
         STYLE_FULL:  return comp_type'($urandom);
         STYLE_SMALL: return comp_type'($urandom_range(0, 1 << 19)) - comp_type'(1 << 18);
         default:     return picks[$urandom_range(0, 6)];
      endcase
   endfunction

   task automatic write_matrix_reg(input logic [CSR_IDX_W-1:0] idx, input csr_type data);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      // Indexes above the last register are dropped by the block.
      if (idx < NUM_REGS)
         matrix_shadow[idx] = data;
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic fill_matrix(input comp_type value);
      for (int i = 0; i < NUM_REGS; i++)
         write_matrix_reg(MATRIX_REGS[i], {value, value});
      matrix_settings++;
   endtask

   task automatic load_matrix(input value_style_type style);
      for (int i = 0; i < NUM_REGS; i++)
         write_matrix_reg(MATRIX_REGS[i], {rand_q(style), rand_q(style)});
      if ($urandom_range(0, 3) == 0)
         write_matrix_reg(CSR_IDX_W'($urandom_range(NUM_REGS, (1 << CSR_IDX_W) - 1)),
                          {$urandom, $urandom});
      matrix_settings++;
   endtask

   task automatic queue_vertex(input comp_type x, y, z, w);
      pending_vertices.push_back({w, z, y, x});
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_vertices.size() != 0 || req_valid || predicted_results.size() != 0);
   endtask

   function automatic int pick_idle();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 5;
         default: return 20;
      endcase
   endfunction

   always @(negedge clock) begin : vertex_driver
      vec_type v;
      // A presented vertex stays put until its transaction completes.
      if (!(req_valid && !req_fired)) begin
         if (send_gap > 0) begin
            send_gap  = send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_vertices.size() > 0) begin
            v = pending_vertices.pop_front();
            req_in_x  <= v[0];
            req_in_y  <= v[1];
            req_in_z  <= v[2];
            req_in_w  <= v[3];
            req_valid <= 1'b1;
            if ($urandom_range(1, 100) <= idle_pct)
               send_gap = $urandom_range(1, 17);
         end else begin
            req_valid <= 1'b0;
         end
      end
      req_fired = 1'b0;
   end

   always @(negedge clock) begin : result_sink
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(1, 100) <= idle_pct)
            stall_left = $urandom_range(1, 17);
      end
   end

   // Results are checked before the vertex of the same edge is recorded,
   // so the order within the edge never matters.
   always @(posedge clock) begin : vertex_monitor
      vertex_result_type want;
      vec_type           got;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_out_w, rsp_out_z, rsp_out_y, rsp_out_x};
            if (predicted_results.size() == 0) begin
               $error("transformed vertex with no vertex outstanding");
               mismatch_count++;
            end else begin
               want = predicted_results.pop_front();
               results_checked++;
               if (want.saturated)
                  saturated_seen++;
               for (int c = 0; c < DIM; c++)
                  if (got[c] !== want.comp[c]) begin
                     $error("%s: expected %h, got %h", comp_names[c], want.comp[c], got[c]);
                     mismatch_count++;
                  end
               if (rsp_saturated !== want.saturated) begin
                  $error("saturated: expected %b, got %b", want.saturated, rsp_saturated);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            predicted_results.push_back(transform_vertex({req_in_w, req_in_z, req_in_y, req_in_x}));
            req_fired = 1'b1;
            vertices_sent++;
         end
      end
   end

   initial begin
      #(20_000_000);
      $display("vertex_transform_4x4_top: mismatch");
      $finish;
   end

   initial begin : stimulus
      value_style_type style;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_in_x  = '0;
      req_in_y  = '0;
      req_in_z  = '0;
      req_in_w  = '0;
      rsp_stall = 1'b0;
      csr_wen   = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      // Identity after reset, the even column in the low half of each register.
      matrix_shadow = '0;
      matrix_shadow[CSR_ROW0_COLS01] = {{COMP_W{1'b0}}, Q_ONE};
      matrix_shadow[CSR_ROW1_COLS01] = {Q_ONE, {COMP_W{1'b0}}};
      matrix_shadow[CSR_ROW2_COLS23] = {{COMP_W{1'b0}}, Q_ONE};
      matrix_shadow[CSR_ROW3_COLS23] = {Q_ONE, {COMP_W{1'b0}}};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Identity matrix straight from reset.
      idle_pct = pick_idle();
      queue_vertex('0, '0, '0, '0);
      queue_vertex(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
      queue_vertex(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
      queue_vertex(comp_type'(1), '1, Q_MAX, Q_MIN);
      queue_vertex(Q_ONE, Q_ONE, Q_ONE, Q_ONE);
      queue_vertex(-Q_ONE, Q_MIN, '0, Q_MAX);
      wait_idle();

      // Largest positive entries: clipping at both ends and a cancelling sum.
      idle_pct = pick_idle();
      fill_matrix(Q_MAX);
      queue_vertex(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
      queue_vertex(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
      queue_vertex(Q_MAX, Q_MIN, Q_MAX, Q_MIN);
      queue_vertex('0, '0, '0, '0);
      queue_vertex(Q_ONE, '0, '0, '0);
      wait_idle();

      // Most negative entries: four products of 2^62 need the full sum width.
      // Writes past the last register must leave the matrix alone.
      idle_pct = pick_idle();
      fill_matrix(Q_MIN);
      write_matrix_reg(CSR_IDX_W'(NUM_REGS), '1);
      write_matrix_reg(CSR_IDX_W'((1 << CSR_IDX_W) - 1), {Q_ONE, Q_ONE});
      queue_vertex(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
      queue_vertex(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
      queue_vertex(comp_type'(1), comp_type'(1), comp_type'(1), comp_type'(1));
      queue_vertex('1, '1, '1, '1);
      queue_vertex(Q_ONE, '0, -Q_ONE, '0);
      wait_idle();

      for (int p = 0; p < 10; p++) begin
         if (p < 4)
            style = value_style_type'(p);
         else
            style = value_style_type'($urandom_range(0, 3));
         // The final phase runs with neither side idling.
         idle_pct = (p == 9) ? 0 : pick_idle();
         load_matrix(style);
         for (int n = 0; n < 104; n++)
            queue_vertex(rand_q(STYLE_MIXED), rand_q(STYLE_MIXED),
                         rand_q(STYLE_MIXED), rand_q(STYLE_MIXED));
         wait_idle();
      end

      repeat (8) @(posedge clock);
      $display("Sent %0d vertices through %0d matrix settings; checked %0d results.",
               vertices_sent, matrix_settings, results_checked);
      $display("%0d results clipped at least one component.", saturated_seen);
      if (mismatch_count == 0)
         $display("vertex_transform_4x4_top: match");
      else
         $display("vertex_transform_4x4_top: mismatch");
      $finish;
   end

endmodule
